### sv/rpb_pkg.sv
package rpb_pkg;

   typedef struct packed {
      logic [7:0] top_red;
      logic [7:0] top_green;
      logic [7:0] top_blue;
      logic [7:0] bottom_red;
      logic [7:0] bottom_green;
      logic [7:0] bottom_blue;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
   } pixel_out_type;

   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BLEND_MODE     = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RED_CONSTANT   = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GREEN_CONSTANT = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BLUE_CONSTANT  = 8'd3;

   localparam logic [2:0] MODE_MULTIPLY = 3'd0;
   localparam logic [2:0] MODE_SCREEN   = 3'd1;
   localparam logic [2:0] MODE_OVERLAY  = 3'd2;
   localparam logic [2:0] MODE_SUBTRACT = 3'd3;
   localparam logic [2:0] MODE_ADD      = 3'd4;
   localparam logic [2:0] MODE_SCALE    = 3'd5;

   localparam logic [15:0] CONSTANT_RESET = 16'd256;
   localparam logic [15:0] ROUND_BIAS     = 16'd127;
   localparam logic [15:0] SCREEN_BIAS    = 16'd65152;
   localparam logic [7:0]  CHANNEL_MAX    = 8'd255;
   localparam logic [9:0]  DIVISOR        = 10'd255;
   localparam logic [9:0]  DIVISOR_TWICE  = 10'd510;

endpackage

### sv/rgb_pixel_blend_unit_core.sv
// Per-pixel RGB blender: each transfer on req_ carries a top and a bottom pixel and yields one
// blended pixel on rsp_, chosen by blend_mode (multiply, screen, overlay, subtract, add constant,
// scale; codes 6 and 7 pass the top pixel through). The block takes one pixel every clock while
// rsp_ready is high; each pixel passes through the input register and then the result register,
// with the three channels worked in parallel lanes of one multiplier and a constant divide by
// 255 each. Back-pressure on rsp_ready holds both registers, so up to two pixels are in flight.
// Write the csr_ registers only while no pixel is in flight.
module rgb_pixel_blend_unit_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rpb_pkg::pixel_in_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rpb_pkg::pixel_out_type              rsp_data,
   input  logic                                csr_write,
   input  logic [rpb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [rpb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic [2:0]             mode_ff;
   logic [15:0]            red_k_ff;
   logic [15:0]            green_k_ff;
   logic [15:0]            blue_k_ff;
   logic                   stage_valid_ff;
   rpb_pkg::pixel_in_type  stage_ff;
   logic                   rsp_valid_ff;
   rpb_pkg::pixel_out_type rsp_ff;
   rpb_pkg::pixel_out_type rsp_in;
   logic                   advance;

   function automatic logic [7:0] blend_channel(input logic [2:0]  mode,
                                                input logic [7:0]  t,
                                                input logic [7:0]  b,
                                                input logic [15:0] k);
      logic        invert;
      logic [7:0]  op_a;
      logic [15:0] op_c;
      logic [23:0] prod;
      logic [15:0] m;
      logic [15:0] num;
      logic [15:0] est_sum;
      logic [7:0]  q_est;
      logic [16:0] rem_wide;
      logic [9:0]  rem;
      logic [8:0]  quot;
      logic [16:0] add_sum;
      logic [7:0]  result;
      invert = (mode == rpb_pkg::MODE_SCREEN) || ((mode == rpb_pkg::MODE_OVERLAY) && b[7]);
      op_a   = invert ? ~t : t;
      op_c   = (mode == rpb_pkg::MODE_SCALE) ? k : {8'd0, (invert ? ~b : b)};
      prod   = {16'd0, op_a} * {8'd0, op_c};
      m      = prod[15:0];
      case (mode)
         rpb_pkg::MODE_MULTIPLY: num = m + rpb_pkg::ROUND_BIAS;
         rpb_pkg::MODE_SCREEN:   num = rpb_pkg::SCREEN_BIAS - m;
         rpb_pkg::MODE_OVERLAY: begin
            if (b[7]) begin
               num = rpb_pkg::SCREEN_BIAS - {m[14:0], 1'b0};
            end else begin
               num = {m[14:0], 1'b0} + rpb_pkg::ROUND_BIAS;
            end
         end
         default:                num = m;
      endcase
      // divide by 255: estimate from n * 257 / 65536, then up to two corrections
      est_sum  = num + {8'd0, num[15:8]};
      q_est    = est_sum[15:8];
      rem_wide = {1'b0, num} + {9'd0, q_est} - {1'b0, q_est, 8'd0};
      rem      = rem_wide[9:0];
      quot     = {1'b0, q_est} + {8'd0, (rem >= rpb_pkg::DIVISOR)}
                 + {8'd0, (rem >= rpb_pkg::DIVISOR_TWICE)};
      add_sum  = {1'b0, t, 8'd0} + {1'b0, k};
      case (mode)
         rpb_pkg::MODE_MULTIPLY,
         rpb_pkg::MODE_SCREEN,
         rpb_pkg::MODE_OVERLAY:  result = quot[7:0];
         rpb_pkg::MODE_SUBTRACT: result = (b < t) ? 8'd0 : (b - t);
         rpb_pkg::MODE_ADD:      result = add_sum[16] ? rpb_pkg::CHANNEL_MAX : add_sum[15:8];
         rpb_pkg::MODE_SCALE:    result = (prod[23:16] != 8'd0) ? rpb_pkg::CHANNEL_MAX
                                                                : prod[15:8];
         default:                result = t;
      endcase
      return result;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= rpb_pkg::MODE_MULTIPLY;
         red_k_ff   <= rpb_pkg::CONSTANT_RESET;
         green_k_ff <= rpb_pkg::CONSTANT_RESET;
         blue_k_ff  <= rpb_pkg::CONSTANT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            rpb_pkg::REG_BLEND_MODE:     mode_ff    <= csr_wdata[2:0];
            rpb_pkg::REG_RED_CONSTANT:   red_k_ff   <= csr_wdata;
            rpb_pkg::REG_GREEN_CONSTANT: green_k_ff <= csr_wdata;
            rpb_pkg::REG_BLUE_CONSTANT:  blue_k_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !stage_valid_ff || advance;

   always_comb begin
      rsp_in.out_red   = blend_channel(mode_ff, stage_ff.top_red, stage_ff.bottom_red, red_k_ff);
      rsp_in.out_green = blend_channel(mode_ff, stage_ff.top_green, stage_ff.bottom_green,
                                       green_k_ff);
      rsp_in.out_blue  = blend_channel(mode_ff, stage_ff.top_blue, stage_ff.bottom_blue,
                                       blue_k_ff);
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (req_ready) begin
            stage_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= stage_valid_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         stage_ff <= req_data;
      end
      if (advance && stage_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### sv/rpb_checker.sv
module rpb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input rpb_pkg::pixel_out_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result needs an earlier request transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without matching request");

   assert property (@(posedge clock) !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   assert property (@(posedge clock) disable iff (reset) rsp_ready |-> req_ready)
      else $error("request stalled while output drains");

endmodule

bind rgb_pixel_blend_unit_core rpb_checker u_rpb_checker (.*);

### tb/tb_top.sv
module tb_top;

   localparam logic [2:0] MODE_BYPASS_ALT = 3'd7;
   localparam logic [rpb_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_FIRST = 8'd4;
   localparam logic [rpb_pkg::CSR_INDEX_WIDTH-1:0] REG_UNUSED_LAST  = 8'd255;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int RANDOM_PHASES   = 12;
   localparam int PIXELS_PER_PHASE = 105;

   class pixel_scoreboard;
      rpb_pkg::pixel_out_type expected_pixels[$];
      logic [2:0]             blend_mode;
      logic [15:0]            channel_constant[3];
      int                     mismatches;
      int                     checked;

      function new();
         blend_mode = rpb_pkg::MODE_MULTIPLY;
         foreach (channel_constant[i]) channel_constant[i] = rpb_pkg::CONSTANT_RESET;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_register(logic [rpb_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 logic [rpb_pkg::CSR_DATA_WIDTH-1:0] data);
         case (index)
            rpb_pkg::REG_BLEND_MODE:     blend_mode = data[2:0];
            rpb_pkg::REG_RED_CONSTANT:   channel_constant[0] = data;
            rpb_pkg::REG_GREEN_CONSTANT: channel_constant[1] = data;
            rpb_pkg::REG_BLUE_CONSTANT:  channel_constant[2] = data;
            default: ;
         endcase
      endfunction

      function logic [7:0] blend_channel(int unsigned t, int unsigned b, int unsigned k);
         int unsigned p;
         int unsigned s;
         p = (255 - t) * (255 - b);
         case (blend_mode)
            rpb_pkg::MODE_MULTIPLY: s = (2 * t * b + 255) / 510;
            rpb_pkg::MODE_SCREEN:   s = (130305 - 2 * p) / 510;
            rpb_pkg::MODE_OVERLAY:  s = (b <= 127) ? (4 * t * b + 255) / 510
                                                   : (130305 - 4 * p) / 510;
            rpb_pkg::MODE_SUBTRACT: s = (b < t) ? 0 : b - t;
            rpb_pkg::MODE_ADD:      s = (t * 256 + k) >> 8;
            rpb_pkg::MODE_SCALE:    s = (t * k) >> 8;
            default:                s = t;
         endcase
         if (s > 255) s = 255;
         return s[7:0];
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      task note_request(rpb_pkg::pixel_in_type p);
         rpb_pkg::pixel_out_type e;
         e.out_red   = blend_channel(32'(p.top_red), 32'(p.bottom_red),
                                     32'(channel_constant[0]));
         e.out_green = blend_channel(32'(p.top_green), 32'(p.bottom_green),
                                     32'(channel_constant[1]));
         e.out_blue  = blend_channel(32'(p.top_blue), 32'(p.bottom_blue),
                                     32'(channel_constant[2]));
         expected_pixels = {expected_pixels, e};
      endtask

      task report_mismatch(string field, int got, int want);
         $display("pixel %0d: %s got %0d, expected %0d", checked, field, got, want);
         mismatches++;
      endtask

      task check_response(rpb_pkg::pixel_out_type p);
         rpb_pkg::pixel_out_type e;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected transfer", int'(p), 0);
         end else begin
            e = expected_pixels.pop_front();
            if (p.out_red !== e.out_red)
               report_mismatch("out_red", int'(p.out_red), int'(e.out_red));
            if (p.out_green !== e.out_green)
               report_mismatch("out_green", int'(p.out_green), int'(e.out_green));
            if (p.out_blue !== e.out_blue)
               report_mismatch("out_blue", int'(p.out_blue), int'(e.out_blue));
         end
         checked++;
      endtask
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   rpb_pkg::pixel_in_type               req_data;
   logic                                rsp_valid;
   logic                                rsp_ready;
   rpb_pkg::pixel_out_type              rsp_data;
   logic                                csr_write;
   logic [rpb_pkg::CSR_INDEX_WIDTH-1:0] csr_index;
   logic [rpb_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata;

   pixel_scoreboard sb = new();
   bit steady = 1'b0;
   int settings_applied = 0;
   int idle_cycles = 0;

   rgb_pixel_blend_unit_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d pixels outstanding", sb.pending());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] rand_channel();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd127;
         3: return 8'd128;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [15:0] rand_constant();
      case ($urandom_range(0, 4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return rpb_pkg::CONSTANT_RESET;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_pixel(rpb_pkg::pixel_in_type p);
      int gap;
      gap = 0;
      if (!steady) while ($urandom_range(0, 99) < 10) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(logic [rpb_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 logic [rpb_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      sb.set_register(index, data);
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(logic [2:0] mode, logic [15:0] red, logic [15:0] green,
                                logic [15:0] blue,
                                logic [rpb_pkg::CSR_INDEX_WIDTH-1:0] stray_index);
      logic [rpb_pkg::CSR_DATA_WIDTH-1:0] mode_word;
      wait_drained();
      // upper bits of the mode word are don't-care
      mode_word = {13'($urandom_range(0, 8191)), mode};
      if ($urandom_range(0, 1) == 0) mode_word[15:3] = '0;
      write_register(stray_index, 16'($urandom_range(0, 65535)));
      write_register(rpb_pkg::REG_BLEND_MODE, mode_word);
      write_register(rpb_pkg::REG_RED_CONSTANT, red);
      write_register(rpb_pkg::REG_GREEN_CONSTANT, green);
      write_register(rpb_pkg::REG_BLUE_CONSTANT, blue);
      settings_applied++;
   endtask

   function automatic rpb_pkg::pixel_in_type directed_pixel(int which);
      rpb_pkg::pixel_in_type p;
      case (which)
         0: p = {8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd127};
         1: p = {8'd255, 8'd0, 8'd127, 8'd0, 8'd255, 8'd128};
         default: p = {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
      endcase
      return p;
   endfunction

   initial begin
      rpb_pkg::pixel_in_type p;
      logic [2:0] mode;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings before any write
      for (int i = 0; i < 3; i++) send_pixel(directed_pixel(i));

      // every mode code at the field and constant extremes
      for (int m = 0; m < 8; m++) begin
         apply_setting(3'(m), (m % 2) ? 16'hFFFF : 16'h0000, (m % 2) ? 16'h0000 : 16'hFFFF,
                       16'h0180, (m % 2) ? REG_UNUSED_LAST : REG_UNUSED_FIRST);
         for (int i = 0; i < 3; i++) send_pixel(directed_pixel(i));
      end

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         mode = (ph < 8) ? 3'(ph)
                         : 3'($urandom_range(rpb_pkg::MODE_MULTIPLY, MODE_BYPASS_ALT));
         apply_setting(mode, rand_constant(), rand_constant(), rand_constant(),
                       8'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)));
         steady = (ph == 3);
         for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
            if (ph == 5 && i == PIXELS_PER_PHASE / 2) wait_drained();
            p.top_red      = rand_channel();
            p.top_green    = rand_channel();
            p.top_blue     = rand_channel();
            p.bottom_red   = rand_channel();
            p.bottom_green = rand_channel();
            p.bottom_blue  = rand_channel();
            send_pixel(p);
         end
         steady = 1'b0;
      end

      wait_drained();
      $display("%0d blended pixels checked over %0d register settings", sb.checked,
               settings_applied);
      $display("covered all eight mode codes, constant extremes and ignored register indexes");
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
